[rtl/rfp_pkg.sv]
// Shared types, constants and the CRC-8 helper of the RC receiver frame parser.
`default_nettype none
package rfp_pkg;

   localparam int FRAME_BYTES = 64;
   localparam int ADDR_W      = $clog2(FRAME_BYTES);
   localparam int POS_W       = $clog2(FRAME_BYTES + 1);
   localparam int CHANNELS    = 16;
   localparam int CSR_ADDR_W  = 4;

   localparam logic [7:0] SYNC_IBUS0    = 8'h20;
   localparam logic [7:0] SYNC_IBUS1    = 8'h40;
   localparam logic [7:0] SYNC_SBUS     = 8'h0F;
   localparam logic [7:0] SYNC_CRSF     = 8'hC8;
   localparam logic [7:0] CRSF_CHANNELS = 8'h16;
   localparam logic [7:0] CRSF_LINK     = 8'h14;
   localparam logic [7:0] CRC_POLY      = 8'hD5;
   localparam int         SBUS_FS_BIT   = 3;

   localparam logic [15:0] CH_CENTER   = 16'd1500;
   localparam logic [15:0] SBUS_OFFSET = 16'd880;
   localparam logic [15:0] CRSF_OFFSET = 16'd881;
   localparam logic [15:0] RSSI_LOW    = 16'd1000;
   localparam logic [15:0] RSSI_HIGH   = 16'd2000;
   localparam logic [7:0]  DIV10_MUL   = 8'd205;
   localparam logic [7:0]  DBM_BASE    = 8'h80;

   localparam logic [15:0] CSR_GAP_RESET     = 16'd3000;
   localparam logic [31:0] CSR_TIMEOUT_RESET = 32'd500000;

   typedef enum logic [1:0] {
      PROTO_NONE = 2'd0,
      PROTO_IBUS = 2'd1,
      PROTO_SBUS = 2'd2,
      PROTO_CRSF = 2'd3
   } proto_type;

   typedef enum logic [1:0] {
      LINK_DISCONNECTED = 2'd0,
      LINK_CONNECTED    = 2'd1,
      LINK_FAILSAFE     = 2'd2,
      LINK_LOST         = 2'd3
   } link_type;

   typedef enum logic [1:0] {
      REG_PROTOCOL     = 2'd0,
      REG_RSSI_CHANNEL = 2'd1,
      REG_BYTE_GAP     = 2'd2,
      REG_LINK_TIMEOUT = 2'd3
   } reg_type;

   typedef enum logic [1:0] {
      FMT_IBUS,
      FMT_SBUS,
      FMT_CRSF
   } fmt_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UNPACK,
      ST_RSSI_MUL,
      ST_RSSI_SET,
      ST_LINK_A,
      ST_LINK_B,
      ST_LINK_C,
      ST_PUBLISH
   } state_type;

   typedef struct packed {
      proto_type   protocol;
      logic [4:0]  rssi_channel;
      logic [15:0] byte_gap;
      logic [31:0] link_timeout;
      logic        clear_position;
   } cfg_type;

   // One full byte of the CRC-8 shift register, MSB first.
   function automatic logic [7:0] crc8_step(input logic [7:0] c_in);
      logic [7:0] c;
      c = c_in;
      for (int j = 0; j < 8; j++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

[rtl/rfp_if.sv]
// Request and response channel interfaces of the RC receiver frame parser.
`default_nettype none
interface rfp_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] data;
   modport source (output valid, command, data, input ready);
   modport sink (input valid, command, data, output ready);
endinterface

interface rfp_rsp_if;
   logic              valid;
   logic              ready;
   logic [3:0]        channel_index;
   logic [15:0]       channel_value;
   logic [4:0]        channel_count;
   logic [1:0]        link_state;
   logic [7:0]        link_quality;
   logic signed [7:0] rssi;
   logic              last;
   modport source (output valid, channel_index, channel_value, channel_count, link_state,
                   link_quality, rssi, last, input ready);
   modport sink (input valid, channel_index, channel_value, channel_count, link_state,
                 link_quality, rssi, last, output ready);
endinterface
`default_nettype wire

[rtl/rfp_csr.sv]
// Configuration registers of the frame parser behind an APB-style port.
`default_nettype none
module rfp_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [rfp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic      [31:0]                    csr_prdata,
   output logic                                csr_pready,
   output rfp_pkg::cfg_type                    cfg
);

   rfp_pkg::proto_type protocol_ff, protocol_in;
   logic [4:0]         rssi_ff, rssi_in;
   logic [15:0]        gap_ff, gap_in;
   logic [31:0]        timeout_ff, timeout_in;
   logic               wr;
   rfp_pkg::reg_type   idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign idx = rfp_pkg::reg_type'(csr_paddr[3:2]);

   always_comb begin
      protocol_in = protocol_ff;
      rssi_in     = rssi_ff;
      gap_in      = gap_ff;
      timeout_in  = timeout_ff;
      if (wr) begin
         case (idx)
            rfp_pkg::REG_PROTOCOL:     protocol_in = rfp_pkg::proto_type'(csr_pwdata[1:0]);
            rfp_pkg::REG_RSSI_CHANNEL: rssi_in     = csr_pwdata[4:0];
            rfp_pkg::REG_BYTE_GAP:     gap_in      = csr_pwdata[15:0];
            rfp_pkg::REG_LINK_TIMEOUT: timeout_in  = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_ff <= rfp_pkg::PROTO_NONE;
         rssi_ff     <= 5'h1F;
         gap_ff      <= rfp_pkg::CSR_GAP_RESET;
         timeout_ff  <= rfp_pkg::CSR_TIMEOUT_RESET;
      end else begin
         protocol_ff <= protocol_in;
         rssi_ff     <= rssi_in;
         gap_ff      <= gap_in;
         timeout_ff  <= timeout_in;
      end
   end

   always_comb begin
      case (idx)
         rfp_pkg::REG_PROTOCOL:     csr_prdata = {30'd0, protocol_ff};
         rfp_pkg::REG_RSSI_CHANNEL: csr_prdata = {{27{rssi_ff[4]}}, rssi_ff};
         rfp_pkg::REG_BYTE_GAP:     csr_prdata = {16'd0, gap_ff};
         rfp_pkg::REG_LINK_TIMEOUT: csr_prdata = timeout_ff;
         default:                   csr_prdata = 32'd0;
      endcase
   end

   always_comb begin
      cfg.protocol       = protocol_ff;
      cfg.rssi_channel   = rssi_ff;
      cfg.byte_gap       = gap_ff;
      cfg.link_timeout   = timeout_ff;
      // The framing position restarts on the same edge as a protocol write.
      cfg.clear_position = wr && (idx == rfp_pkg::REG_PROTOCOL);
   end

endmodule
`default_nettype wire

[rtl/rfp_unpack.sv]
// Shared bit-stream unit: collects frame bytes and peels off whole channels.
`default_nettype none
module rfp_unpack (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             clear,
   input  wire logic             byte_valid,
   input  wire logic [7:0]       byte_data,
   input  wire rfp_pkg::fmt_type fmt,
   output logic                  emit,
   output logic [15:0]           value
);

   logic [23:0] bits_ff, bits_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        wide;
   logic [10:0] raw11;
   logic [13:0] raw_x5;

   assign wide   = (fmt == rfp_pkg::FMT_IBUS);
   assign emit   = wide ? (cnt_ff >= 5'd16) : (cnt_ff >= 5'd11);
   assign raw11  = bits_ff[10:0];
   assign raw_x5 = {1'b0, raw11, 2'b00} + {3'b000, raw11};

   always_comb begin
      if (wide) begin
         value = bits_ff[15:0];
      end else if (fmt == rfp_pkg::FMT_CRSF) begin
         value = {5'd0, raw_x5[13:3]} + rfp_pkg::CRSF_OFFSET;
      end else begin
         value = {5'd0, raw_x5[13:3]} + rfp_pkg::SBUS_OFFSET;
      end
   end

   always_comb begin
      bits_in = bits_ff;
      cnt_in  = cnt_ff;
      if (emit) begin
         bits_in = wide ? (bits_ff >> 16) : (bits_ff >> 11);
         cnt_in  = wide ? (cnt_ff - 5'd16) : (cnt_ff - 5'd11);
      end
      if (byte_valid) begin
         bits_in = bits_in | ({16'd0, byte_data} << cnt_in);
         cnt_in  = cnt_in + 5'd8;
      end
      if (clear) begin
         bits_in = '0;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         bits_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         bits_ff <= bits_in;
      end
   end

endmodule
`default_nettype wire

[rtl/rc_receiver_frame_parser.sv]
// Top level of the RC receiver frame parser: sequencer, frame store and status.
//
// Requests carry either a received UART byte (command 0) or one time tick
// (command 1). A byte or a tick that completes nothing leaves the block idle.
// When a frame is accepted, or the link timeout first expires, the block sends
// 16 responses, channels 0 to 15, each with the shared link status; last marks
// channel 15. Frame checks run on the fly while bytes arrive, so the completing
// byte only starts the channel unpack: one shared bit-stream unit reads the
// frame store through its single registered read port, one byte a cycle, 22
// bytes for S.Bus/CRSF and 28 for iBus, then the RSSI multiply and set steps
// for iBus RSSI or the link field reads for a CRSF link frame, then the
// responses. The block takes no request from a completion until its last
// response is loaded into the output register. A stalled receiver holds the
// responses; the output register is the only buffer. Reset restores the
// channel values to 1500, the link to disconnected and the frame store to
// zeros at once (per-entry valid bits); configuration starts at protocol none.
`default_nettype none
module rc_receiver_frame_parser (
   input  wire logic                           clock,
   input  wire logic                           reset,
   rfp_req_if.sink                             req_chan,
   rfp_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [rfp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic      [31:0]                    csr_prdata,
   output logic                                csr_pready
);

   localparam int AW = rfp_pkg::ADDR_W;
   localparam int PW = rfp_pkg::POS_W;

   rfp_pkg::cfg_type   cfg;
   rfp_pkg::state_type state_ff, state_in;
   rfp_pkg::fmt_type   fmt_ff, fmt_in;
   rfp_pkg::link_type  status_ff, status_in;

   logic [PW-1:0] pos_ff, pos_in;
   logic [31:0]   gap_ff, gap_in;
   logic [31:0]   link_ff, link_in;
   logic [4:0]    total_ff, total_in;
   logic [7:0]    quality_ff, quality_in;
   logic [7:0]    dbm_ff, dbm_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    type_ff, type_in;
   logic          flag_ff, flag_in;
   logic [7:0]    b30_ff, b30_in;
   logic [15:0]   sum_ff, sum_in;
   logic [7:0]    crc_ff, crc_in;
   logic [4:0]    rd_cnt_ff, rd_cnt_in;
   logic [4:0]    ch_ff, ch_in;
   logic [15:0]   rssi_v_ff, rssi_v_in;
   logic [17:0]   prod_ff, prod_in;
   logic [3:0]    k_ff, k_in;
   logic          rd_pend_ff, rd_pend_in;

   logic [rfp_pkg::FRAME_BYTES-1:0] valid_ff, valid_in;
   logic [7:0]    mem [rfp_pkg::FRAME_BYTES];
   logic [7:0]    rdata_ff;
   logic          rvld_ff;
   logic [7:0]    rbyte;
   logic          mem_we;
   logic [AW-1:0] widx;
   logic [AW-1:0] raddr;

   logic [15:0]   chv_ff [rfp_pkg::CHANNELS];
   logic          chv_we;
   logic [3:0]    chv_idx;
   logic [15:0]   chv_val;

   logic          out_valid_ff, out_valid_in;
   logic          out_load;

   logic          up_clear;
   logic          up_emit;
   logic [15:0]   up_value;

   logic [PW-1:0] p0;
   logic [PW-1:0] pnew;
   logic [31:0]   link_inc;
   logic          rssi_en;
   logic [4:0]    nreads;
   logic [4:0]    nch;
   logic [AW-1:0] base;
   logic [9:0]    rssi_x;
   logic [6:0]    q;

   rfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rfp_unpack u_unpack (
      .clock      (clock),
      .reset      (reset),
      .clear      (up_clear),
      .byte_valid (rd_pend_ff),
      .byte_data  (rbyte),
      .fmt        (fmt_ff),
      .emit       (up_emit),
      .value      (up_value)
   );

   assign rbyte    = rvld_ff ? rdata_ff : 8'd0;
   assign rssi_en  = (cfg.rssi_channel < 5'd14);
   assign link_inc = (link_ff == 32'hFFFF_FFFF) ? link_ff : link_ff + 32'd1;
   assign req_chan.ready = (state_ff == rfp_pkg::ST_IDLE);

   always_comb begin
      case (fmt_ff)
         rfp_pkg::FMT_IBUS: begin
            nreads = 5'd28;
            nch    = 5'd14;
            base   = AW'(2);
         end
         rfp_pkg::FMT_CRSF: begin
            nreads = 5'd22;
            nch    = 5'd16;
            base   = AW'(3);
         end
         default: begin
            nreads = 5'd22;
            nch    = 5'd16;
            base   = AW'(1);
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      fmt_in     = fmt_ff;
      status_in  = status_ff;
      pos_in     = pos_ff;
      gap_in     = gap_ff;
      link_in    = link_ff;
      total_in   = total_ff;
      quality_in = quality_ff;
      dbm_in     = dbm_ff;
      len_in     = len_ff;
      type_in    = type_ff;
      flag_in    = flag_ff;
      b30_in     = b30_ff;
      sum_in     = sum_ff;
      crc_in     = crc_ff;
      rd_cnt_in  = rd_cnt_ff;
      ch_in      = ch_ff;
      rssi_v_in  = rssi_v_ff;
      prod_in    = prod_ff;
      k_in       = k_ff;
      rd_pend_in = 1'b0;
      valid_in   = valid_ff;
      mem_we     = 1'b0;
      raddr      = '0;
      chv_we     = 1'b0;
      chv_idx    = ch_ff[3:0];
      chv_val    = up_value;
      out_load   = 1'b0;
      up_clear   = 1'b0;
      rssi_x     = '0;
      q          = prod_ff[17:11];
      p0         = pos_ff;
      if (gap_ff > {16'd0, cfg.byte_gap}) begin
         p0 = '0;
      end
      if (p0 >= PW'(rfp_pkg::FRAME_BYTES)) begin
         p0 = '0;
      end
      widx = p0[AW-1:0];
      pnew = p0 + PW'(1);

      case (state_ff)
         rfp_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.command) begin
                  gap_in  = (gap_ff == 32'hFFFF_FFFF) ? gap_ff : gap_ff + 32'd1;
                  link_in = link_inc;
                  if (cfg.protocol != rfp_pkg::PROTO_NONE && link_inc > cfg.link_timeout &&
                      status_ff != rfp_pkg::LINK_LOST) begin
                     status_in = rfp_pkg::LINK_LOST;
                     k_in      = '0;
                     state_in  = rfp_pkg::ST_PUBLISH;
                  end
               end else if (cfg.protocol != rfp_pkg::PROTO_NONE) begin
                  mem_we         = 1'b1;
                  valid_in[widx] = 1'b1;
                  gap_in         = '0;
                  pos_in         = pnew;
                  if (widx == AW'(1)) len_in = req_chan.data;
                  if (widx == AW'(2)) type_in = req_chan.data;
                  if (widx == AW'(23)) flag_in = req_chan.data[rfp_pkg::SBUS_FS_BIT];
                  if (widx == AW'(30)) b30_in = req_chan.data;
                  // Running iBus checksum over bytes 0 to 29 of the frame.
                  if (widx == AW'(0)) begin
                     sum_in = 16'hFFFF - {8'd0, req_chan.data};
                  end else if (widx < AW'(30)) begin
                     sum_in = sum_ff - {8'd0, req_chan.data};
                  end
                  // Running CRSF CRC from byte 2; the completing byte is the CRC itself.
                  if (widx == AW'(2)) begin
                     crc_in = rfp_pkg::crc8_step(req_chan.data);
                  end else if (widx > AW'(2)) begin
                     crc_in = rfp_pkg::crc8_step(crc_ff ^ req_chan.data);
                  end
                  case (cfg.protocol)
                     rfp_pkg::PROTO_IBUS: begin
                        if ((pnew == PW'(1) && req_chan.data != rfp_pkg::SYNC_IBUS0) ||
                            (pnew == PW'(2) && req_chan.data != rfp_pkg::SYNC_IBUS1)) begin
                           pos_in = '0;
                        end else if (pnew == PW'(32)) begin
                           pos_in = '0;
                           if (sum_ff == {req_chan.data, b30_ff}) begin
                              total_in  = 5'd14;
                              status_in = rfp_pkg::LINK_CONNECTED;
                              link_in   = '0;
                              fmt_in    = rfp_pkg::FMT_IBUS;
                              rd_cnt_in = '0;
                              ch_in     = '0;
                              up_clear  = 1'b1;
                              state_in  = rfp_pkg::ST_UNPACK;
                           end
                        end
                     end
                     rfp_pkg::PROTO_SBUS: begin
                        if (pnew == PW'(1) && req_chan.data != rfp_pkg::SYNC_SBUS) begin
                           pos_in = '0;
                        end else if (pnew == PW'(25)) begin
                           pos_in    = '0;
                           total_in  = 5'd16;
                           if (flag_ff) begin
                              status_in = rfp_pkg::LINK_FAILSAFE;
                           end else begin
                              status_in = rfp_pkg::LINK_CONNECTED;
                              link_in   = '0;
                           end
                           fmt_in    = rfp_pkg::FMT_SBUS;
                           rd_cnt_in = '0;
                           ch_in     = '0;
                           up_clear  = 1'b1;
                           state_in  = rfp_pkg::ST_UNPACK;
                        end
                     end
                     rfp_pkg::PROTO_CRSF: begin
                        if (pnew == PW'(1) && req_chan.data != rfp_pkg::SYNC_CRSF) begin
                           pos_in = '0;
                        end else if (pnew == PW'(2) &&
                                     (req_chan.data > 8'(rfp_pkg::FRAME_BYTES - 2) ||
                                      req_chan.data < 8'd2)) begin
                           pos_in = '0;
                        end else if (pnew > PW'(2) &&
                                     {{(9 - PW){1'b0}}, pnew} >= ({1'b0, len_ff} + 9'd2)) begin
                           pos_in = '0;
                           if (crc_ff == req_chan.data) begin
                              k_in = '0;
                              if (type_ff == rfp_pkg::CRSF_CHANNELS) begin
                                 total_in  = 5'd16;
                                 status_in = rfp_pkg::LINK_CONNECTED;
                                 link_in   = '0;
                                 fmt_in    = rfp_pkg::FMT_CRSF;
                                 rd_cnt_in = '0;
                                 ch_in     = '0;
                                 up_clear  = 1'b1;
                                 state_in  = rfp_pkg::ST_UNPACK;
                              end else if (type_ff == rfp_pkg::CRSF_LINK) begin
                                 state_in = rfp_pkg::ST_LINK_A;
                              end else begin
                                 state_in = rfp_pkg::ST_PUBLISH;
                              end
                           end
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end

         rfp_pkg::ST_UNPACK: begin
            if (rd_cnt_ff < nreads) begin
               raddr      = base + rd_cnt_ff[AW-1:0];
               rd_pend_in = 1'b1;
               rd_cnt_in  = rd_cnt_ff + 5'd1;
            end
            if (up_emit) begin
               chv_we = 1'b1;
               if (fmt_ff == rfp_pkg::FMT_IBUS && rssi_en &&
                   ch_ff[3:0] == cfg.rssi_channel[3:0]) begin
                  rssi_v_in = up_value;
                  chv_val   = rfp_pkg::CH_CENTER;
               end
               ch_in = ch_ff + 5'd1;
               if (ch_ff == nch - 5'd1) begin
                  k_in = '0;
                  if (fmt_ff == rfp_pkg::FMT_IBUS && rssi_en) begin
                     state_in = rfp_pkg::ST_RSSI_MUL;
                  end else begin
                     state_in = rfp_pkg::ST_PUBLISH;
                  end
               end
            end
         end

         rfp_pkg::ST_RSSI_MUL: begin
            // Quality is (v - 1000) / 10, taken as a multiply by 205 and a shift by 11.
            if (rssi_v_ff < rfp_pkg::RSSI_LOW) begin
               rssi_x = '0;
            end else if (rssi_v_ff > rfp_pkg::RSSI_HIGH) begin
               rssi_x = 10'd1000;
            end else begin
               rssi_x = 10'(rssi_v_ff - rfp_pkg::RSSI_LOW);
            end
            prod_in  = {8'd0, rssi_x} * {10'd0, rfp_pkg::DIV10_MUL};
            state_in = rfp_pkg::ST_RSSI_SET;
         end

         rfp_pkg::ST_RSSI_SET: begin
            quality_in = {1'b0, q};
            dbm_in     = rfp_pkg::DBM_BASE + ((q < 7'd2) ? 8'd0 : {1'b0, q - 7'd2});
            state_in   = rfp_pkg::ST_PUBLISH;
         end

         rfp_pkg::ST_LINK_A: begin
            raddr    = AW'(3);
            state_in = rfp_pkg::ST_LINK_B;
         end

         rfp_pkg::ST_LINK_B: begin
            raddr    = AW'(5);
            dbm_in   = 8'd0 - rbyte;
            state_in = rfp_pkg::ST_LINK_C;
         end

         rfp_pkg::ST_LINK_C: begin
            quality_in = rbyte;
            state_in   = rfp_pkg::ST_PUBLISH;
         end

         rfp_pkg::ST_PUBLISH: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_load = 1'b1;
               k_in     = k_ff + 4'd1;
               if (k_ff == 4'd15) begin
                  state_in = rfp_pkg::ST_IDLE;
               end
            end
         end

         default: state_in = rfp_pkg::ST_IDLE;
      endcase

      if (cfg.clear_position) begin
         pos_in = '0;
      end

      out_valid_in = out_valid_ff;
      if (rsp_chan.ready) out_valid_in = 1'b0;
      if (out_load) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rfp_pkg::ST_IDLE;
         fmt_ff     <= rfp_pkg::FMT_IBUS;
         status_ff  <= rfp_pkg::LINK_DISCONNECTED;
         pos_ff     <= '0;
         gap_ff     <= '0;
         link_ff    <= '0;
         total_ff   <= '0;
         quality_ff <= '0;
         dbm_ff     <= rfp_pkg::DBM_BASE;
         rd_cnt_ff  <= '0;
         ch_ff      <= '0;
         k_ff       <= '0;
         rd_pend_ff <= 1'b0;
         valid_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fmt_ff     <= fmt_in;
         status_ff  <= status_in;
         pos_ff     <= pos_in;
         gap_ff     <= gap_in;
         link_ff    <= link_in;
         total_ff   <= total_in;
         quality_ff <= quality_in;
         dbm_ff     <= dbm_in;
         rd_cnt_ff  <= rd_cnt_in;
         ch_ff      <= ch_in;
         k_ff       <= k_in;
         rd_pend_ff <= rd_pend_in;
         valid_ff   <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff    <= len_in;
      type_ff   <= type_in;
      flag_ff   <= flag_in;
      b30_ff    <= b30_in;
      sum_ff    <= sum_in;
      crc_ff    <= crc_in;
      rssi_v_ff <= rssi_v_in;
      prod_ff   <= prod_in;
   end

   // Frame store with one write and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[widx] <= req_chan.data;
      end
      rdata_ff <= mem[raddr];
      rvld_ff  <= valid_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rfp_pkg::CHANNELS; i++) begin
            chv_ff[i] <= rfp_pkg::CH_CENTER;
         end
      end else if (chv_we) begin
         chv_ff[chv_idx] <= chv_val;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_chan.channel_index <= k_ff;
         rsp_chan.channel_value <= chv_ff[k_ff];
         rsp_chan.channel_count <= total_ff;
         rsp_chan.link_state    <= status_ff;
         rsp_chan.link_quality  <= quality_ff;
         rsp_chan.rssi          <= dbm_ff;
         rsp_chan.last          <= (k_ff == 4'd15);
      end
   end

   assign rsp_chan.valid = out_valid_ff;

endmodule
`default_nettype wire

[verif/rc_receiver_frame_parser_tb.sv]
// Self-checking testbench of the RC receiver frame parser: iBus, S.Bus and CRSF frames, ticks.
`default_nettype none
module rc_receiver_frame_parser_tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_TICKS = 64;

   typedef struct {
      logic [3:0]  ch_index;
      logic [15:0] ch_value;
      logic [4:0]  ch_count;
      logic [1:0]  ch_link;
      logic [7:0]  ch_quality;
      logic [7:0]  ch_rssi;
      logic        ch_last;
   } channel_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rfp_req_if req ();
   rfp_rsp_if rsp ();

   rc_receiver_frame_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req),
      .rsp_chan   (rsp),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Predicted parser state and configuration.
   logic [7:0]  frame_mem[rfp_pkg::FRAME_BYTES];
   int unsigned frame_pos;
   logic [31:0] since_byte;
   logic [31:0] since_frame;
   logic [15:0] chan_val[rfp_pkg::CHANNELS];
   logic [4:0]  chan_total;
   logic [1:0]  link_now;
   logic [7:0]  quality_now;
   logic [7:0]  dbm_now;
   logic [1:0]  cfg_proto;
   logic [4:0]  cfg_rssi_ch;
   logic [15:0] cfg_gap;
   logic [31:0] cfg_timeout;

   channel_result_type expected_channels[$];
   int errors = 0;
   int cycles = 0;
   int items_sent = 0;
   int channels_seen = 0;
   int frames_published = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int tick_inject_pct = 0;

   always #6 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.command = 1'b0;
      req.data = '0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      channel_result_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         channels_seen++;
         if (expected_channels.size() == 0) begin
            $error("unexpected response for channel %0d", rsp.channel_index);
            errors++;
         end else begin
            e = expected_channels.pop_front();
            if (rsp.channel_index !== e.ch_index) begin
               $error("channel_index expected %0d actual %0d", e.ch_index, rsp.channel_index);
               errors++;
            end
            if (rsp.channel_value !== e.ch_value) begin
               $error("channel_value expected %0d actual %0d", e.ch_value, rsp.channel_value);
               errors++;
            end
            if (rsp.channel_count !== e.ch_count) begin
               $error("channel_count expected %0d actual %0d", e.ch_count, rsp.channel_count);
               errors++;
            end
            if (rsp.link_state !== e.ch_link) begin
               $error("link_state expected %0d actual %0d", e.ch_link, rsp.link_state);
               errors++;
            end
            if (rsp.link_quality !== e.ch_quality) begin
               $error("link_quality expected %0d actual %0d", e.ch_quality, rsp.link_quality);
               errors++;
            end
            if (rsp.rssi !== e.ch_rssi) begin
               $error("rssi expected %0d actual %0d", $signed(e.ch_rssi), rsp.rssi);
               errors++;
            end
            if (rsp.last !== e.ch_last) begin
               $error("last expected %0d actual %0d", e.ch_last, rsp.last);
               errors++;
            end
         end
      end
   end

   function automatic logic [7:0] crc8_update(input logic [7:0] c_in, input logic [7:0] b);
      logic [7:0] c;
      c = c_in ^ b;
      for (int j = 0; j < 8; j++) c = c[7] ? ((c << 1) ^ 8'hD5) : (c << 1);
      return c;
   endfunction

   function automatic logic [7:0] stored_byte(input int unsigned i);
      return (i < rfp_pkg::FRAME_BYTES) ? frame_mem[i] : 8'h00;
   endfunction

   task automatic queue_channels();
      channel_result_type r;
      for (int k = 0; k < 16; k++) begin
         r.ch_index = 4'(k);
         r.ch_value = chan_val[k];
         r.ch_count = chan_total;
         r.ch_link = link_now;
         r.ch_quality = quality_now;
         r.ch_rssi = dbm_now;
         r.ch_last = (k == 15);
         expected_channels.push_back(r);
      end
      frames_published++;
   endtask

   // Channels are packed as 16 little-endian 11-bit fields.
   task automatic unpack_channels(input int unsigned base, input logic [15:0] offset);
      int unsigned bitpos;
      int unsigned at;
      logic [31:0] w;
      logic [31:0] raw;
      for (int i = 0; i < 16; i++) begin
         bitpos = 11 * i;
         at = base + bitpos / 8;
         w = {8'h00, stored_byte(at + 2), stored_byte(at + 1), stored_byte(at)};
         raw = (w >> (bitpos % 8)) & 32'h7FF;
         chan_val[i] = 16'((raw * 5) >> 3) + offset;
      end
      chan_total = 5'd16;
   endtask

   task automatic ibus_frame_done(output bit done);
      logic [15:0] sum;
      int unsigned v;
      int unsigned q;
      done = 0;
      if (frame_pos == 1 && frame_mem[0] != rfp_pkg::SYNC_IBUS0) begin
         frame_pos = 0;
         return;
      end
      if (frame_pos == 2 && frame_mem[1] != rfp_pkg::SYNC_IBUS1) begin
         frame_pos = 0;
         return;
      end
      if (frame_pos != 32) return;
      frame_pos = 0;
      sum = 16'hFFFF;
      for (int i = 0; i < 30; i++) sum = sum - frame_mem[i];
      if (sum != {frame_mem[31], frame_mem[30]}) return;
      for (int i = 0; i < 14; i++) chan_val[i] = {frame_mem[3 + 2 * i], frame_mem[2 + 2 * i]};
      chan_total = 5'd14;
      link_now = rfp_pkg::LINK_CONNECTED;
      since_frame = 0;
      if (cfg_rssi_ch < 14) begin
         v = chan_val[cfg_rssi_ch];
         if (v < 1000) v = 1000;
         if (v > 2000) v = 2000;
         q = (v - 1000) / 10;
         quality_now = 8'(q);
         // Below quality 2 the dBm value would fall under -128 and saturates.
         dbm_now = 8'h80 + 8'((q < 2) ? 0 : q - 2);
         chan_val[cfg_rssi_ch] = rfp_pkg::CH_CENTER;
      end
      done = 1;
   endtask

   task automatic sbus_frame_done(output bit done);
      done = 0;
      if (frame_pos == 1 && frame_mem[0] != rfp_pkg::SYNC_SBUS) begin
         frame_pos = 0;
         return;
      end
      if (frame_pos != 25) return;
      frame_pos = 0;
      unpack_channels(1, rfp_pkg::SBUS_OFFSET);
      if (frame_mem[23][rfp_pkg::SBUS_FS_BIT]) begin
         link_now = rfp_pkg::LINK_FAILSAFE;
      end else begin
         link_now = rfp_pkg::LINK_CONNECTED;
         since_frame = 0;
      end
      done = 1;
   endtask

   task automatic crsf_frame_done(output bit done);
      int unsigned len;
      int unsigned total;
      logic [7:0] c;
      done = 0;
      if (frame_pos == 1 && frame_mem[0] != rfp_pkg::SYNC_CRSF) begin
         frame_pos = 0;
         return;
      end
      if (frame_pos < 2) return;
      len = frame_mem[1];
      if (frame_pos == 2 && (len > rfp_pkg::FRAME_BYTES - 2 || len < 2)) begin
         frame_pos = 0;
         return;
      end
      total = len + 2;
      if (frame_pos < total) return;
      frame_pos = 0;
      c = 8'h00;
      for (int unsigned i = 0; i < total - 3; i++) c = crc8_update(c, stored_byte(2 + i));
      if (c != stored_byte(total - 1)) return;
      if (frame_mem[2] == rfp_pkg::CRSF_CHANNELS) begin
         unpack_channels(3, rfp_pkg::CRSF_OFFSET);
         link_now = rfp_pkg::LINK_CONNECTED;
         since_frame = 0;
      end else if (frame_mem[2] == rfp_pkg::CRSF_LINK) begin
         dbm_now = 8'h00 - frame_mem[3];
         quality_now = frame_mem[5];
      end
      done = 1;
   endtask

   task automatic decode_request(input logic cmd, input logic [7:0] d);
      bit done;
      if (cmd) begin
         if (since_byte != 32'hFFFF_FFFF) since_byte++;
         if (since_frame != 32'hFFFF_FFFF) since_frame++;
         if (cfg_proto != rfp_pkg::PROTO_NONE && since_frame > cfg_timeout &&
             link_now != rfp_pkg::LINK_LOST) begin
            link_now = rfp_pkg::LINK_LOST;
            queue_channels();
         end
         return;
      end
      if (cfg_proto == rfp_pkg::PROTO_NONE) return;
      if (since_byte > cfg_gap) frame_pos = 0;
      since_byte = 0;
      if (frame_pos >= rfp_pkg::FRAME_BYTES) frame_pos = 0;
      frame_mem[frame_pos] = d;
      frame_pos++;
      case (cfg_proto)
         rfp_pkg::PROTO_IBUS: ibus_frame_done(done);
         rfp_pkg::PROTO_SBUS: sbus_frame_done(done);
         default: crsf_frame_done(done);
      endcase
      if (done) queue_channels();
   endtask

   task automatic send_item(input logic cmd, input logic [7:0] d);
      while ($urandom_range(99) < req_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.command <= cmd;
      req.data <= d;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      decode_request(cmd, d);
      items_sent++;
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_item(1'b1, 8'($urandom_range(255)));
   endtask

   task automatic send_bytes(input logic [7:0] b[$]);
      foreach (b[i]) begin
         if ($urandom_range(99) < tick_inject_pct) send_ticks($urandom_range(1, 3));
         send_item(1'b0, b[i]);
      end
   endtask

   // Waits until every response has come back, then lets the sequencer settle.
   task automatic wait_idle();
      req.valid <= 1'b0;
      @(posedge clock);
      while (expected_channels.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic csr_write(input rfp_pkg::reg_type idx, input logic [31:0] val);
      wait_idle();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         rfp_pkg::REG_PROTOCOL: begin cfg_proto = val[1:0]; frame_pos = 0; end
         rfp_pkg::REG_RSSI_CHANNEL: cfg_rssi_ch = val[4:0];
         rfp_pkg::REG_BYTE_GAP: cfg_gap = val[15:0];
         default: cfg_timeout = val;
      endcase
   endtask

   task automatic configure(input rfp_pkg::proto_type p, input int rssi_ch,
                            input logic [15:0] gap, input logic [31:0] timeout);
      csr_write(rfp_pkg::REG_PROTOCOL, 32'(p));
      csr_write(rfp_pkg::REG_RSSI_CHANNEL, 32'(rssi_ch) & 32'h1F);
      csr_write(rfp_pkg::REG_BYTE_GAP, 32'(gap));
      csr_write(rfp_pkg::REG_LINK_TIMEOUT, timeout);
   endtask

   // A negative slot leaves every channel random.
   task automatic send_ibus(input bit corrupt, input int slot, input logic [15:0] slot_value);
      logic [7:0] b[$];
      logic [15:0] v;
      logic [15:0] sum;
      b = {rfp_pkg::SYNC_IBUS0, rfp_pkg::SYNC_IBUS1};
      for (int i = 0; i < 14; i++) begin
         v = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1000, 2000));
         if (i == slot) v = slot_value;
         b.push_back(v[7:0]);
         b.push_back(v[15:8]);
      end
      sum = 16'hFFFF;
      foreach (b[i]) sum = sum - b[i];
      b.push_back(sum[7:0]);
      b.push_back(sum[15:8]);
      if (corrupt) b[$urandom_range(31)] ^= 8'($urandom_range(1, 255));
      send_bytes(b);
   endtask

   task automatic send_sbus(input bit failsafe, input bit bad_sync);
      logic [7:0] b[$];
      logic [7:0] flags;
      b = {bad_sync ? 8'($urandom_range(16, 255)) : rfp_pkg::SYNC_SBUS};
      repeat (22) b.push_back(8'($urandom));
      flags = 8'($urandom);
      flags[rfp_pkg::SBUS_FS_BIT] = failsafe;
      b.push_back(flags);
      b.push_back(8'h00);
      send_bytes(b);
   endtask

   // Lengths outside 2..62 are cut short after a few bytes, as the parser restarts anyway.
   task automatic send_crsf(input logic [7:0] kind, input int len, input bit corrupt);
      logic [7:0] b[$];
      logic [7:0] c;
      b = {rfp_pkg::SYNC_CRSF, 8'(len)};
      if (len < 2 || len > rfp_pkg::FRAME_BYTES - 2) begin
         repeat ($urandom_range(1, 4)) b.push_back(8'($urandom));
         send_bytes(b);
         return;
      end
      b.push_back(kind);
      repeat (len - 2) b.push_back(8'($urandom));
      c = 8'h00;
      for (int i = 2; i < b.size(); i++) c = crc8_update(c, b[i]);
      b.push_back(corrupt ? c ^ 8'($urandom_range(1, 255)) : c);
      send_bytes(b);
   endtask

   task automatic send_noise(input int n);
      repeat (n) send_item(1'b0, 8'($urandom));
   endtask

   task automatic test_protocol_none();
      configure(rfp_pkg::PROTO_NONE, -1, rfp_pkg::CSR_GAP_RESET, 0);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hFF);
      send_ticks(3);
   endtask

   task automatic test_ibus();
      configure(rfp_pkg::PROTO_IBUS, 13, rfp_pkg::CSR_GAP_RESET, rfp_pkg::CSR_TIMEOUT_RESET);
      send_ibus(0, 13, 16'd900);
      csr_write(rfp_pkg::REG_RSSI_CHANNEL, 32'd0);
      send_ibus(0, 0, 16'hFFFF);
      csr_write(rfp_pkg::REG_RSSI_CHANNEL, 32'd14);
      send_ibus(1, -1, 0);
   endtask

   task automatic test_sbus();
      configure(rfp_pkg::PROTO_SBUS, -1, rfp_pkg::CSR_GAP_RESET, rfp_pkg::CSR_TIMEOUT_RESET);
      send_sbus(0, 0);
      send_sbus(1, 0);
   endtask

   task automatic test_crsf();
      configure(rfp_pkg::PROTO_CRSF, -1, rfp_pkg::CSR_GAP_RESET, rfp_pkg::CSR_TIMEOUT_RESET);
      send_crsf(rfp_pkg::CRSF_CHANNELS, 24, 0);
      send_crsf(rfp_pkg::CRSF_LINK, 12, 0);
      send_crsf(8'h29, 2, 0);
      // A short channel frame still unpacks older bytes of the store.
      send_crsf(rfp_pkg::CRSF_CHANNELS, 5, 0);
      send_crsf(rfp_pkg::CRSF_CHANNELS, 1, 0);
   endtask

   task automatic test_gap_restart();
      configure(rfp_pkg::PROTO_CRSF, -1, 16'd2, rfp_pkg::CSR_TIMEOUT_RESET);
      send_noise(3);
      send_ticks(3);
      send_crsf(rfp_pkg::CRSF_LINK, 12, 0);
   endtask

   task automatic test_link_timeout();
      configure(rfp_pkg::PROTO_CRSF, -1, rfp_pkg::CSR_GAP_RESET, 32'd5);
      send_crsf(rfp_pkg::CRSF_CHANNELS, 5, 0);
      send_ticks(7);
   endtask

   initial begin
      for (int i = 0; i < rfp_pkg::FRAME_BYTES; i++) frame_mem[i] = 8'h00;
      for (int i = 0; i < rfp_pkg::CHANNELS; i++) chan_val[i] = rfp_pkg::CH_CENTER;
      frame_pos = 0;
      since_byte = 0;
      since_frame = 0;
      chan_total = 5'd0;
      link_now = rfp_pkg::LINK_DISCONNECTED;
      quality_now = 8'h00;
      dbm_now = rfp_pkg::DBM_BASE;
      cfg_proto = rfp_pkg::PROTO_NONE;
      cfg_rssi_ch = 5'h1F;
      cfg_gap = rfp_pkg::CSR_GAP_RESET;
      cfg_timeout = rfp_pkg::CSR_TIMEOUT_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tick_inject_pct = 3;

      req_idle_pct = 13;
      rsp_idle_pct = 70;
      test_protocol_none();
      test_ibus();

      req_idle_pct = 70;
      rsp_idle_pct = 13;
      test_sbus();
      test_crsf();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_gap_restart();
      test_link_timeout();

      wait_idle();
      $display("Drove %0d requests through iBus, S.Bus and CRSF framing, gaps and timeouts.",
               items_sent);
      $display("Compared %0d channel responses across %0d publications.", channels_seen,
               frames_published);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
